@@ rtl/core/ibmw_pkg.sv @@
package ibmw_pkg;

  localparam int unsigned OpW    = 2;
  localparam int unsigned FileW  = 13;
  localparam int unsigned BlkW   = 12;
  localparam int unsigned StatW  = 2;
  localparam int unsigned CountW = 13;
  localparam logic [CountW-1:0] CountMax = 13'd8191;

  // entries per pointer block, a power of two so the index splits into fields
  localparam int unsigned PtrsPerBlk = 64;

  localparam logic [OpW-1:0] OpLookup = 2'd0;
  localparam logic [OpW-1:0] OpMap    = 2'd1;
  localparam logic [OpW-1:0] OpClear  = 2'd2;
  localparam logic [OpW-1:0] OpNone   = 2'd3;

  localparam logic [StatW-1:0] StOk    = 2'd0;
  localparam logic [StatW-1:0] StHole  = 2'd1;
  localparam logic [StatW-1:0] StNoBlk = 2'd2;
  localparam logic [StatW-1:0] StRange = 2'd3;

  typedef enum logic [1:0] {
    KindDirect = 2'd0,
    KindSingle = 2'd1,
    KindDouble = 2'd2,
    KindRange  = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    StIdle,
    StDecode,
    StRdRoot,
    StRdWait,
    StPlan,
    StWipe1,
    StLink1,
    StWipe2,
    StLink2,
    StWriteLeaf,
    StRdLeaf,
    StLeafWait,
    StDone
  } state_e;

  typedef struct packed {
    logic [OpW-1:0]   opcode;
    logic [FileW-1:0] file_idx;
    logic [BlkW-1:0]  data_block;
    logic [BlkW-1:0]  spare_first;
    logic [BlkW-1:0]  spare_second;
  } req_t;

  typedef struct packed {
    logic [BlkW-1:0]   disk_block;
    logic [StatW-1:0]  status;
    logic              used_data;
    logic              used_first;
    logic              used_second;
    logic [CountW-1:0] blocks_in_use;
  } rsp_t;

endpackage

@@ rtl/core/ibmw_if.sv @@
interface ibmw_req_if;
  logic           valid;
  logic           ready;
  ibmw_pkg::req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface ibmw_rsp_if;
  logic           valid;
  logic           ready;
  ibmw_pkg::rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/core/ibmw_store.sv @@
// pointer store: one write or one read port per cycle, registered read data
module ibmw_store #(
  parameter int unsigned AddrW = 18,
  parameter int unsigned DataW = 12
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [DataW-1:0] wdata_i,
  output logic [DataW-1:0] rdata_o
);
  logic [DataW-1:0] mem_q [2**AddrW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

@@ rtl/core/inode_block_map_walker_core.sv @@
// inode block map walker: lookup, map and clear over a direct/indirect block map
// lookup of a double-indirect entry takes two dependent reads (first-level, then leaf)
// map wipes every entry of each pointer block that it takes before linking it in
// one request at a time: the next request is accepted once the response has been taken
// reset: direct pointers, roots and block count clear at once; the store is not cleared
module inode_block_map_walker_core #(
  parameter int unsigned DIRECT_POINTERS = 12
) (
  input  logic clk_i,
  input  logic rst_ni,
  ibmw_req_if.sink   req_i,
  ibmw_rsp_if.source rsp_o
);
  localparam int unsigned BlkW   = ibmw_pkg::BlkW;
  localparam int unsigned FileW  = ibmw_pkg::FileW;
  localparam int unsigned CountW = ibmw_pkg::CountW;
  localparam int unsigned Ptrs   = ibmw_pkg::PtrsPerBlk;
  localparam int unsigned IdxW   = (Ptrs > 1) ? $clog2(Ptrs) : 1;
  localparam int unsigned NumW   = BlkW;
  localparam int unsigned AddrW  = NumW + IdxW;
  localparam int unsigned DirW   = (DIRECT_POINTERS > 1) ? $clog2(DIRECT_POINTERS) : 1;
  // wide enough for the largest reduced index
  localparam int unsigned RW     = 2 * IdxW + 2;
  localparam logic [RW-1:0] PLim  = RW'(Ptrs);
  localparam logic [RW:0]   PPLim = (RW + 1)'(Ptrs * Ptrs);
  localparam logic [FileW-1:0] DLim = FileW'(DIRECT_POINTERS);

  // --------------------------------------------------------------------------
  // map state
  // --------------------------------------------------------------------------
  logic [NumW-1:0]   dir_q [DIRECT_POINTERS];
  logic [NumW-1:0]   single_q, double_q;
  logic [CountW-1:0] count_q, count_d;

  // captured request
  ibmw_pkg::req_t    req_q;
  ibmw_pkg::kind_e   kind_q;
  logic [IdxW-1:0]   i1_q, i2_q;  // single index uses i2_q
  logic [DirW-1:0]   di_q;
  logic [NumW-1:0]   l1_q, data_n, s1_n, s2_n;
  logic              need_root_q, need_l1_q;

  // result
  ibmw_pkg::rsp_t    rsp_q, rsp_d;
  logic              rsp_valid_q;

  ibmw_pkg::state_e  state_q, state_d;
  logic [IdxW-1:0]   wipe_q;

  // shared store port
  logic              st_we;
  logic [AddrW-1:0]  st_addr;
  logic [NumW-1:0]   st_wdata, st_rdata;

  ibmw_store #(.AddrW(AddrW), .DataW(NumW)) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .addr_i  (st_addr),
    .wdata_i (st_wdata),
    .rdata_o (st_rdata)
  );

  assign data_n = req_q.data_block[NumW-1:0];
  assign s1_n   = req_q.spare_first[NumW-1:0];
  assign s2_n   = req_q.spare_second[NumW-1:0];

  // index decode: both subtracts are combinational, compared and registered in StDecode
  logic [FileW:0]  rel;
  logic [FileW:0]  rel2;
  always_comb begin
    rel  = {1'b0, req_q.file_idx} - {1'b0, DLim};
    rel2 = rel - (FileW + 1)'(Ptrs);
  end

  assign req_i.ready = (state_q == ibmw_pkg::StIdle) && !rsp_valid_q;
  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

  // --------------------------------------------------------------------------
  // next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ibmw_pkg::StIdle: begin
        if (req_i.valid && req_i.ready) state_d = ibmw_pkg::StDecode;
      end
      ibmw_pkg::StDecode:  state_d = ibmw_pkg::StRdRoot;
      ibmw_pkg::StRdRoot: begin
        // only a double-indirect path with a root needs a first-level read
        if (kind_q == ibmw_pkg::KindDouble && double_q != '0 &&
            req_q.opcode != ibmw_pkg::OpNone) begin
          state_d = ibmw_pkg::StRdWait;
        end else begin
          state_d = ibmw_pkg::StPlan;
        end
      end
      ibmw_pkg::StRdWait:  state_d = ibmw_pkg::StPlan;
      ibmw_pkg::StPlan: begin
        state_d = ibmw_pkg::StDone;
        if (req_q.opcode == ibmw_pkg::OpLookup && kind_q != ibmw_pkg::KindDirect &&
            kind_q != ibmw_pkg::KindRange) begin
          if ((kind_q == ibmw_pkg::KindSingle && single_q != '0) ||
              (kind_q == ibmw_pkg::KindDouble && l1_q != '0)) begin
            state_d = ibmw_pkg::StRdLeaf;
          end
        end else if (req_q.opcode == ibmw_pkg::OpMap && kind_q != ibmw_pkg::KindRange &&
                     data_n != '0 && !(need_root_q && s1_n == '0) &&
                     !(need_root_q && need_l1_q && s2_n == '0) &&
                     !(!need_root_q && need_l1_q && s1_n == '0)) begin
          if (kind_q == ibmw_pkg::KindDirect) state_d = ibmw_pkg::StDone;
          else if (need_root_q)               state_d = ibmw_pkg::StWipe1;
          else if (need_l1_q)                 state_d = ibmw_pkg::StWipe2;
          else                                state_d = ibmw_pkg::StWriteLeaf;
        end else if (req_q.opcode == ibmw_pkg::OpClear && kind_q != ibmw_pkg::KindRange &&
                     kind_q != ibmw_pkg::KindDirect) begin
          if ((kind_q == ibmw_pkg::KindSingle && single_q != '0) ||
              (kind_q == ibmw_pkg::KindDouble && l1_q != '0)) begin
            state_d = ibmw_pkg::StWriteLeaf;
          end
        end
      end
      ibmw_pkg::StWipe1: begin
        if (wipe_q == IdxW'(Ptrs - 1)) state_d = ibmw_pkg::StLink1;
      end
      ibmw_pkg::StLink1: begin
        state_d = need_l1_q ? ibmw_pkg::StWipe2 : ibmw_pkg::StWriteLeaf;
      end
      ibmw_pkg::StWipe2: begin
        if (wipe_q == IdxW'(Ptrs - 1)) state_d = ibmw_pkg::StLink2;
      end
      ibmw_pkg::StLink2:     state_d = ibmw_pkg::StWriteLeaf;
      ibmw_pkg::StWriteLeaf: state_d = ibmw_pkg::StDone;
      ibmw_pkg::StRdLeaf:    state_d = ibmw_pkg::StLeafWait;
      ibmw_pkg::StLeafWait:  state_d = ibmw_pkg::StDone;
      ibmw_pkg::StDone:      state_d = ibmw_pkg::StIdle;
      default:               state_d = ibmw_pkg::StIdle;
    endcase
  end

  // block number of the second-level pointer block taken on this map
  logic [NumW-1:0] l1_spare;
  assign l1_spare = need_root_q ? s2_n : s1_n;

  // --------------------------------------------------------------------------
  // store port drive
  // --------------------------------------------------------------------------
  always_comb begin
    st_we    = 1'b0;
    st_addr  = '0;
    st_wdata = '0;
    case (state_q)
      ibmw_pkg::StRdRoot: st_addr = {double_q, i1_q};
      ibmw_pkg::StWipe1: begin
        st_we   = 1'b1;
        st_addr = {s1_n, wipe_q};
      end
      ibmw_pkg::StLink1: ;
      ibmw_pkg::StWipe2: begin
        st_we   = 1'b1;
        st_addr = {l1_spare, wipe_q};
      end
      ibmw_pkg::StLink2: begin
        st_we    = 1'b1;
        st_addr  = {double_q, i1_q};
        st_wdata = l1_spare;
      end
      ibmw_pkg::StWriteLeaf: begin
        st_we    = 1'b1;
        st_addr  = (kind_q == ibmw_pkg::KindSingle) ? {single_q, i2_q} : {l1_q, i2_q};
        st_wdata = (req_q.opcode == ibmw_pkg::OpMap) ? data_n : '0;
      end
      ibmw_pkg::StRdLeaf: begin
        st_addr = (kind_q == ibmw_pkg::KindSingle) ? {single_q, i2_q} : {l1_q, i2_q};
      end
      default: ;
    endcase
  end

  // saturating increment of the block count
  logic [CountW-1:0] count_inc;
  assign count_inc = (count_q == ibmw_pkg::CountMax) ? count_q : count_q + 1'b1;

  always_comb begin
    count_d = count_q;
    case (state_q)
      ibmw_pkg::StLink1, ibmw_pkg::StLink2: count_d = count_inc;
      ibmw_pkg::StDone: begin
        if (rsp_q.used_data) count_d = count_inc;
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // result build
  // --------------------------------------------------------------------------
  always_comb begin
    rsp_d = rsp_q;
    case (state_q)
      ibmw_pkg::StPlan: begin
        rsp_d = '0;
        if (req_q.opcode == ibmw_pkg::OpNone) begin
          rsp_d.status = ibmw_pkg::StOk;
        end else if (kind_q == ibmw_pkg::KindRange) begin
          rsp_d.status = ibmw_pkg::StRange;
        end else if (req_q.opcode == ibmw_pkg::OpLookup) begin
          if (kind_q == ibmw_pkg::KindDirect) begin
            rsp_d.disk_block = BlkW'(dir_q[di_q]);
            rsp_d.status     = (dir_q[di_q] != '0) ? ibmw_pkg::StOk : ibmw_pkg::StHole;
          end else begin
            rsp_d.status = ibmw_pkg::StHole;
          end
        end else if (req_q.opcode == ibmw_pkg::OpClear) begin
          if (kind_q == ibmw_pkg::KindSingle && single_q == '0) rsp_d.status = ibmw_pkg::StHole;
          if (kind_q == ibmw_pkg::KindDouble && l1_q == '0)     rsp_d.status = ibmw_pkg::StHole;
        end else if (state_d == ibmw_pkg::StDone && kind_q != ibmw_pkg::KindDirect) begin
          rsp_d.status = ibmw_pkg::StNoBlk;
        end else if (kind_q == ibmw_pkg::KindDirect && data_n == '0) begin
          rsp_d.status = ibmw_pkg::StNoBlk;
        end else begin
          rsp_d.used_data   = 1'b1;
          rsp_d.disk_block  = BlkW'(data_n);
          rsp_d.used_first  = need_root_q || need_l1_q;
          rsp_d.used_second = need_root_q && need_l1_q;
        end
      end
      ibmw_pkg::StLeafWait: begin
        rsp_d.disk_block = BlkW'(st_rdata);
        rsp_d.status     = (st_rdata != '0) ? ibmw_pkg::StOk : ibmw_pkg::StHole;
      end
      ibmw_pkg::StDone: rsp_d.blocks_in_use = count_d;
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ibmw_pkg::StIdle;
      rsp_valid_q <= 1'b0;
      single_q    <= '0;
      double_q    <= '0;
      count_q     <= '0;
      wipe_q      <= '0;
      for (int i = 0; i < int'(DIRECT_POINTERS); i++) dir_q[i] <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (rsp_valid_q && rsp_o.ready) rsp_valid_q <= 1'b0;
      case (state_q)
        ibmw_pkg::StWipe1, ibmw_pkg::StWipe2: wipe_q <= wipe_q + 1'b1;
        default: wipe_q <= '0;
      endcase
      if (state_q == ibmw_pkg::StLink1) begin
        if (kind_q == ibmw_pkg::KindSingle) single_q <= s1_n;
        else                                double_q <= s1_n;
      end
      if (state_q == ibmw_pkg::StPlan && kind_q == ibmw_pkg::KindDirect) begin
        if (req_q.opcode == ibmw_pkg::OpClear) dir_q[di_q] <= '0;
        else if (req_q.opcode == ibmw_pkg::OpMap && data_n != '0) dir_q[di_q] <= data_n;
      end
      if (state_q == ibmw_pkg::StDone) begin
        rsp_valid_q <= 1'b1;
      end
    end
  end

  // request capture and working payload
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      req_q <= req_i.payload;
    end
    case (state_q)
      ibmw_pkg::StDecode: begin
        di_q <= DirW'(req_q.file_idx);
        if (req_q.file_idx < DLim) begin
          kind_q <= ibmw_pkg::KindDirect;
        end else if (rel[FileW:0] < (FileW + 1)'(PLim)) begin
          kind_q <= ibmw_pkg::KindSingle;
          i2_q   <= IdxW'(rel);
        end else if ((RW + 1)'(rel2) < PPLim && rel2 < (FileW + 1)'(PPLim)) begin
          kind_q <= ibmw_pkg::KindDouble;
          i1_q   <= IdxW'(rel2 >> IdxW);
          i2_q   <= IdxW'(rel2);
        end else begin
          kind_q <= ibmw_pkg::KindRange;
        end
      end
      ibmw_pkg::StRdRoot: begin
        l1_q        <= '0;
        need_root_q <= (kind_q == ibmw_pkg::KindSingle) ? (single_q == '0) :
                       (kind_q == ibmw_pkg::KindDouble) ? (double_q == '0) : 1'b0;
        need_l1_q   <= (kind_q == ibmw_pkg::KindDouble);
      end
      ibmw_pkg::StRdWait: ;
      ibmw_pkg::StLink2: l1_q <= l1_spare;
      ibmw_pkg::StLink1: ;
      default: ;
    endcase
    // first-level pointer arrives in the cycle after the read in StRdRoot
    if (state_q == ibmw_pkg::StRdWait) begin
      l1_q      <= st_rdata;
      need_l1_q <= (st_rdata == '0);
    end

    rsp_q <= rsp_d;
  end
endmodule

@@ verif/ibmw_checker.sv @@
`timescale 1ns / 1ps

module ibmw_checker #(
  parameter int unsigned DIRECT_POINTERS = 12
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  ibmw_req_if   req_mon,
  ibmw_rsp_if   rsp_mon,
  output int    fail_count_o,
  output int    pending_o
);

  localparam int unsigned Ptrs = ibmw_pkg::PtrsPerBlk;

  // shadow of the block map
  logic [ibmw_pkg::BlkW-1:0]   direct_map [DIRECT_POINTERS];
  logic [ibmw_pkg::BlkW-1:0]   single_blk;
  logic [ibmw_pkg::BlkW-1:0]   double_blk;
  logic [ibmw_pkg::BlkW-1:0]   ptr_table [int];
  logic [ibmw_pkg::CountW-1:0] held_count;

  ibmw_pkg::rsp_t expected_rsp_q[$];

  initial begin
    foreach (direct_map[i]) direct_map[i] = '0;
    single_blk   = '0;
    double_blk   = '0;
    held_count   = '0;
    fail_count_o = 0;
    pending_o    = 0;
  end

  function automatic logic [ibmw_pkg::BlkW-1:0] table_rd(logic [ibmw_pkg::BlkW-1:0] blk, int idx);
    int key;
    key = int'(blk) * Ptrs + idx;
    return ptr_table.exists(key) ? ptr_table[key] : '0;
  endfunction

  function automatic void table_wr(logic [ibmw_pkg::BlkW-1:0] blk, int idx,
                                   logic [ibmw_pkg::BlkW-1:0] v);
    ptr_table[int'(blk) * Ptrs + idx] = v;
  endfunction

  function automatic void take_pointer_block(logic [ibmw_pkg::BlkW-1:0] blk);
    for (int i = 0; i < Ptrs; i++) table_wr(blk, i, '0);
    if (held_count < ibmw_pkg::CountMax) held_count++;
  endfunction

  // walks the map for one request and applies its effect
  function automatic ibmw_pkg::rsp_t walk_block_map(ibmw_pkg::req_t rq);
    ibmw_pkg::rsp_t            rs;
    ibmw_pkg::kind_e           kind;
    int                        rel;
    int                        i1;
    int                        i2;
    int                        need;
    logic [ibmw_pkg::BlkW-1:0] l1;
    logic [ibmw_pkg::BlkW-1:0] v;
    logic [ibmw_pkg::BlkW-1:0] sp;
    rs   = '0;
    rel  = 0;
    i1   = 0;
    i2   = 0;
    if (rq.file_idx < DIRECT_POINTERS) begin
      kind = ibmw_pkg::KindDirect;
    end else begin
      rel = int'(rq.file_idx) - DIRECT_POINTERS;
      if (rel < Ptrs) begin
        kind = ibmw_pkg::KindSingle;
      end else begin
        rel -= Ptrs;
        if (rel < Ptrs * Ptrs) begin
          kind = ibmw_pkg::KindDouble;
          i1   = rel / Ptrs;
          i2   = rel % Ptrs;
        end else begin
          kind = ibmw_pkg::KindRange;
        end
      end
    end

    if (rq.opcode != ibmw_pkg::OpLookup && rq.opcode != ibmw_pkg::OpMap &&
        rq.opcode != ibmw_pkg::OpClear) begin
      // unused opcode, nothing happens
    end else if (kind == ibmw_pkg::KindRange) begin
      rs.status = ibmw_pkg::StRange;
    end else if (rq.opcode == ibmw_pkg::OpLookup) begin
      v = '0;
      if (kind == ibmw_pkg::KindDirect) begin
        v = direct_map[rq.file_idx];
      end else if (kind == ibmw_pkg::KindSingle) begin
        if (single_blk != 0) v = table_rd(single_blk, rel);
      end else if (double_blk != 0) begin
        l1 = table_rd(double_blk, i1);
        if (l1 != 0) v = table_rd(l1, i2);
      end
      rs.disk_block = v;
      rs.status     = (v != 0) ? ibmw_pkg::StOk : ibmw_pkg::StHole;
    end else if (rq.opcode == ibmw_pkg::OpClear) begin
      if (kind == ibmw_pkg::KindDirect) begin
        direct_map[rq.file_idx] = '0;
      end else if (kind == ibmw_pkg::KindSingle) begin
        if (single_blk != 0) table_wr(single_blk, rel, '0);
        else rs.status = ibmw_pkg::StHole;
      end else begin
        l1 = (double_blk != 0) ? table_rd(double_blk, i1) : '0;
        if (l1 != 0) table_wr(l1, i2, '0);
        else rs.status = ibmw_pkg::StHole;
      end
    end else if (rq.data_block == 0) begin
      rs.status = ibmw_pkg::StNoBlk;
    end else begin
      need = 0;
      if (kind == ibmw_pkg::KindSingle) need = (single_blk == 0) ? 1 : 0;
      else if (kind == ibmw_pkg::KindDouble) begin
        if (double_blk == 0) need = 2;
        else need = (table_rd(double_blk, i1) == 0) ? 1 : 0;
      end
      if ((need >= 1 && rq.spare_first == 0) || (need >= 2 && rq.spare_second == 0)) begin
        rs.status = ibmw_pkg::StNoBlk;
      end else begin
        if (kind == ibmw_pkg::KindDirect) begin
          direct_map[rq.file_idx] = rq.data_block;
        end else if (kind == ibmw_pkg::KindSingle) begin
          if (need != 0) begin
            take_pointer_block(rq.spare_first);
            single_blk    = rq.spare_first;
            rs.used_first = 1'b1;
          end
          table_wr(single_blk, rel, rq.data_block);
        end else begin
          if (double_blk == 0) begin
            take_pointer_block(rq.spare_first);
            double_blk    = rq.spare_first;
            rs.used_first = 1'b1;
          end
          l1 = table_rd(double_blk, i1);
          if (l1 == 0) begin
            sp = rs.used_first ? rq.spare_second : rq.spare_first;
            take_pointer_block(sp);
            table_wr(double_blk, i1, sp);
            if (rs.used_first) rs.used_second = 1'b1;
            else rs.used_first = 1'b1;
            l1 = sp;
          end
          table_wr(l1, i2, rq.data_block);
        end
        if (held_count < ibmw_pkg::CountMax) held_count++;
        rs.used_data  = 1'b1;
        rs.disk_block = rq.data_block;
      end
    end
    rs.blocks_in_use = held_count;
    return rs;
  endfunction

  function automatic void check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i) begin
    ibmw_pkg::rsp_t want;
    ibmw_pkg::rsp_t got;
    if (rst_ni) begin
      if (req_mon.valid && req_mon.ready) begin
        expected_rsp_q.push_back(walk_block_map(req_mon.payload));
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        got = rsp_mon.payload;
        if (expected_rsp_q.size() == 0) begin
          $display("%0t: response with none expected, actual %p", $time, got);
          fail_count_o++;
        end else begin
          want = expected_rsp_q.pop_front();
          check_field("disk_block", want.disk_block, got.disk_block);
          check_field("status", want.status, got.status);
          check_field("used_data", want.used_data, got.used_data);
          check_field("used_first", want.used_first, got.used_first);
          check_field("used_second", want.used_second, got.used_second);
          check_field("blocks_in_use", want.blocks_in_use, got.blocks_in_use);
        end
      end
      pending_o = expected_rsp_q.size();
    end
  end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  // pointer blocks set up by the directed part; the double root is never
  // handed out again so its table only ever holds second-level pointers
  localparam logic [ibmw_pkg::BlkW-1:0] SingleRootBlk = 12'h5A5;
  localparam logic [ibmw_pkg::BlkW-1:0] DoubleRootBlk = 12'hC3A;
  localparam logic [ibmw_pkg::BlkW-1:0] FirstLeafBlk  = 12'h3F0;

  // first file block past the double-indirect range
  localparam int unsigned RangeEnd = 12 + 64 + 64 * 64;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   tx_idle_pct;
  int   rx_idle_pct;
  logic long_stall_req;

  ibmw_req_if req_if ();
  ibmw_rsp_if rsp_if ();

  inode_block_map_walker_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  ibmw_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_mon      (req_if),
    .rsp_mon      (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard stop in case the block hangs
  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

  // response side: random back-pressure plus one long hold-off on request
  always @(posedge clk_i) begin
    int hold_left;
    logic hold_done;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
    end else if (hold_left > 0) begin
      rsp_if.ready <= 1'b0;
      hold_left--;
    end else if (long_stall_req && !hold_done) begin
      // long enough that the block backs up into its request side
      rsp_if.ready <= 1'b0;
      hold_left = 400;
      hold_done = 1'b1;
    end else begin
      rsp_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // offer one request, idling first as the current phase asks
  task automatic send_request(ibmw_pkg::req_t rq);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= rq;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  task automatic send_op(logic [ibmw_pkg::OpW-1:0] op, int fb, int data, int s1, int s2);
    ibmw_pkg::req_t rq;
    rq.opcode       = op;
    rq.file_idx     = fb[ibmw_pkg::FileW-1:0];
    rq.data_block   = data[ibmw_pkg::BlkW-1:0];
    rq.spare_first  = s1[ibmw_pkg::BlkW-1:0];
    rq.spare_second = s2[ibmw_pkg::BlkW-1:0];
    send_request(rq);
  endtask

  // spare block: sometimes none, never the double root
  function automatic logic [ibmw_pkg::BlkW-1:0] pick_spare(logic [ibmw_pkg::BlkW-1:0] data);
    logic [ibmw_pkg::BlkW-1:0] v;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) v = '0;
    else if (roll < 15 && data != 0) v = data;  // collide with the data block
    else v = ibmw_pkg::BlkW'($urandom_range(1, 4095));
    if (v == DoubleRootBlk) v = v ^ 12'h001;
    return v;
  endfunction

  function automatic ibmw_pkg::req_t random_request();
    ibmw_pkg::req_t rq;
    int roll;
    int i1;
    roll = $urandom_range(0, 99);
    if (roll < 30) rq.opcode = ibmw_pkg::OpLookup;
    else if (roll < 75) rq.opcode = ibmw_pkg::OpMap;
    else if (roll < 93) rq.opcode = ibmw_pkg::OpClear;
    else rq.opcode = ibmw_pkg::OpNone;

    roll = $urandom_range(0, 99);
    if (roll < 20) begin
      rq.file_idx = ibmw_pkg::FileW'($urandom_range(0, 11));
    end else if (roll < 45) begin
      rq.file_idx = ibmw_pkg::FileW'(12 + $urandom_range(0, 63));
    end else if (roll < 90) begin
      // most double-indirect traffic lands on a few second-level blocks
      i1 = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 7) : $urandom_range(0, 63);
      rq.file_idx = ibmw_pkg::FileW'(76 + i1 * 64 + $urandom_range(0, 63));
    end else begin
      rq.file_idx = ibmw_pkg::FileW'($urandom_range(RangeEnd, 8191));
    end

    rq.data_block   = ($urandom_range(0, 99) < 8) ? 12'd0 : 12'($urandom_range(1, 4095));
    rq.spare_first  = pick_spare(rq.data_block);
    rq.spare_second = ($urandom_range(0, 99) < 8) ? rq.spare_first : pick_spare(rq.data_block);
    return rq;
  endfunction

  task automatic send_random(int count);
    for (int n = 0; n < count; n++) send_request(random_request());
  endtask

  initial begin
    rst_ni         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    rsp_if.ready   = 1'b0;
    long_stall_req = 1'b0;
    tx_idle_pct    = 21;
    rx_idle_pct    = 49;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty map: holes, range errors, no-op opcode
    send_op(ibmw_pkg::OpLookup, 0, 0, 0, 0);
    send_op(ibmw_pkg::OpLookup, 11, 0, 0, 0);
    send_op(ibmw_pkg::OpLookup, 12, 0, 0, 0);
    send_op(ibmw_pkg::OpLookup, RangeEnd - 1, 0, 0, 0);
    send_op(ibmw_pkg::OpLookup, RangeEnd, 0, 0, 0);
    send_op(ibmw_pkg::OpMap, 8191, 4095, 4095, 4095);
    send_op(ibmw_pkg::OpClear, 8191, 0, 0, 0);
    send_op(ibmw_pkg::OpNone, 100, 4095, 4095, 4095);
    send_op(ibmw_pkg::OpClear, 200, 0, 0, 0);
    // map without a data block, then direct maps at both ends
    send_op(ibmw_pkg::OpMap, 0, 0, 0, 0);
    send_op(ibmw_pkg::OpMap, 0, 4095, 0, 0);
    send_op(ibmw_pkg::OpMap, 11, 1, 0, 0);
    // single indirect: no spare, then take the root
    send_op(ibmw_pkg::OpMap, 12, 5, 0, 0);
    send_op(ibmw_pkg::OpMap, 12, 12'hABC, SingleRootBlk, 0);
    send_op(ibmw_pkg::OpMap, 75, 7, 0, 0);
    // double indirect: second spare missing, then both taken
    send_op(ibmw_pkg::OpMap, 76, 9, DoubleRootBlk, 0);
    send_op(ibmw_pkg::OpMap, 76, 12'h800, DoubleRootBlk, FirstLeafBlk);
    send_op(ibmw_pkg::OpMap, RangeEnd - 1, 4095, 12'h7FF, 12'h7FF);
    send_op(ibmw_pkg::OpLookup, 76, 0, 0, 0);
    send_op(ibmw_pkg::OpLookup, RangeEnd - 1, 0, 0, 0);
    send_op(ibmw_pkg::OpClear, 76, 0, 0, 0);
    send_op(ibmw_pkg::OpLookup, 76, 0, 0, 0);
    send_op(ibmw_pkg::OpClear, 5, 0, 0, 0);
    // overwrite a mapped pointer
    send_op(ibmw_pkg::OpMap, 0, 12'h555, 0, 0);
    send_op(ibmw_pkg::OpLookup, 0, 0, 0, 0);

    send_random(60);
    long_stall_req <= 1'b1;
    send_random(420);

    tx_idle_pct = 49;
    rx_idle_pct = 21;
    send_random(480);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_random(490);
    req_if.valid <= 1'b0;

    do begin
      @(posedge clk_i);
      #1;
    end while (pending != 0);
    repeat (200) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ inode_block_map_walker_core.f @@
rtl/core/ibmw_pkg.sv
rtl/core/ibmw_if.sv
rtl/core/ibmw_store.sv
rtl/core/inode_block_map_walker_core.sv
verif/ibmw_checker.sv
verif/testbench.sv
